/* hw/rtl/mrhc_pkg.sv */
// Shared types and constants for the memory run hole carver.
`timescale 1ns / 1ps
package mrhc_pkg;

    // Default depth of the run table.
    localparam int MAX_RUNS_DEF = 16;

    // Field widths fixed by the interface.
    localparam int ADDR_W  = 64;
    localparam int INDEX_W = 4;
    localparam int TOTAL_W = 5;

    // Page rounding masks for a 4 KiB page.
    localparam logic [ADDR_W-1:0] PAGE_MASK_HIGH = 64'hFFFF_FFFF_FFFF_F000;
    localparam logic [ADDR_W-1:0] PAGE_MASK_LOW  = 64'h0000_0000_0000_0FFF;

    // Operation codes of the shared adder.
    typedef enum logic [1:0] {
        ALU_ADD  = 2'd0,   // a + b
        ALU_ADD1 = 2'd1,   // a + b + 1
        ALU_SUB  = 2'd2,   // a - b, borrow gives a < b
        ALU_SUB1 = 2'd3    // a - b - 1
    } alu_op_t;

    // Request to the shared adder.
    typedef struct packed {
        alu_op_t           op;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
    } alu_req_t;

    // Answer from the shared adder.
    typedef struct packed {
        logic [ADDR_W-1:0] sum;
        logic              lt;
    } alu_rsp_t;

endpackage

/* hw/rtl/mrhc_alu.sv */
// Shared 64-bit add, subtract and compare unit of the hole carver.
`timescale 1ns / 1ps
module mrhc_alu (
    input  mrhc_pkg::alu_req_t req,
    output mrhc_pkg::alu_rsp_t rsp
);

    logic [mrhc_pkg::ADDR_W-1:0] b_sel;
    logic                        cin;
    logic [mrhc_pkg::ADDR_W:0]   full;

    // Pick the second operand polarity and the carry in for each operation.
    always_comb
    begin
        b_sel = req.b;
        cin   = 1'b0;
        unique case (req.op)
            mrhc_pkg::ALU_ADD:
            begin
                b_sel = req.b;
                cin   = 1'b0;
            end
            mrhc_pkg::ALU_ADD1:
            begin
                b_sel = req.b;
                cin   = 1'b1;
            end
            mrhc_pkg::ALU_SUB:
            begin
                b_sel = ~req.b;
                cin   = 1'b1;
            end
            mrhc_pkg::ALU_SUB1:
            begin
                b_sel = ~req.b;
                cin   = 1'b0;
            end
            default:
            begin
                b_sel = req.b;
                cin   = 1'b0;
            end
        endcase
    end

    // One carry chain; for a subtract a missing carry out means a < b.
    assign full    = {1'b0, req.a} + {1'b0, b_sel} + {{mrhc_pkg::ADDR_W{1'b0}}, cin};
    assign rsp.sum = full[mrhc_pkg::ADDR_W-1:0];
    assign rsp.lt  = ~full[mrhc_pkg::ADDR_W];

endmodule

/* hw/rtl/memory_run_hole_carver_core.sv */
// Top level of the memory run hole carver: run table, sequencer and result beat.
`timescale 1ns / 1ps
// A read loads the indexed entry and then gives its done beat. An insert loads each run in turn
// and compares it one test at a time, rewrites base and then length for a trimmed run, and moves each entry up
// on a split; the shared adder/comparator and the single table read port serialise these steps.
// busy stays high from the accepted start until the done beat; the next start is
// taken the cycle after. After reset the table holds one run, base 0 with all-ones
// byte count; the receiver cannot stall, so done is a one-cycle strobe.
module memory_run_hole_carver_core #(
    parameter int MAX_RUNS = mrhc_pkg::MAX_RUNS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         mode,
    input  logic [mrhc_pkg::ADDR_W-1:0]  hole_start,
    input  logic [mrhc_pkg::ADDR_W-1:0]  hole_end,
    input  logic [mrhc_pkg::INDEX_W-1:0] run_index,
    output logic                         done,
    output logic [mrhc_pkg::ADDR_W-1:0]  run_base,
    output logic [mrhc_pkg::ADDR_W-1:0]  run_bytes,
    output logic [mrhc_pkg::TOTAL_W-1:0] run_total,
    output logic                         overflow,
    output logic                         index_valid
);

    localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int CW = $clog2(MAX_RUNS + 1);
    localparam int IW = (CW > mrhc_pkg::INDEX_W) ? CW : mrhc_pkg::INDEX_W;
    localparam int TW = (CW > mrhc_pkg::TOTAL_W) ? CW : mrhc_pkg::TOTAL_W;
    localparam int DW = mrhc_pkg::ADDR_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RUNS);
    localparam logic [CW-1:0] ONE_CNT = CW'(1);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_READ   = 14'b00000000000010,
        S_LOAD   = 14'b00000000000100,
        S_C1     = 14'b00000000001000,
        S_C2     = 14'b00000000010000,
        S_C3     = 14'b00000000100000,
        S_C4     = 14'b00000001000000,
        S_SPL_A  = 14'b00000010000000,
        S_SH_RD  = 14'b00000100000000,
        S_SH_WR  = 14'b00001000000000,
        S_SPL_B  = 14'b00010000000000,
        S_TRIM_A = 14'b00100000000000,
        S_TRIM_B = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // Item and scan registers.
    logic          mode_reg, mode_next;
    logic [DW-1:0] start_reg, start_next;
    logic [DW-1:0] end_reg, end_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] count_reg, count_next;
    logic [DW-1:0] rs_reg, rs_next;
    logic [DW-1:0] re_reg, re_next;
    logic          ovf_reg, ovf_next;
    logic          valid_reg, valid_next;
    logic [DW-1:0] res_base_reg, res_base_next;
    logic [DW-1:0] res_bytes_reg, res_bytes_next;

    // Run table and its ports.
    logic [DW-1:0] base_mem [MAX_RUNS];
    logic [DW-1:0] len_mem  [MAX_RUNS];
    logic [DW-1:0] base_q_reg;
    logic [DW-1:0] len_q_reg;
    logic          base0_fresh_reg;
    logic          len0_fresh_reg;
    logic          base_q0_reg;
    logic          len_q0_reg;
    logic [AW-1:0] rd_addr;
    logic          base_we;
    logic [AW-1:0] base_wa;
    logic [DW-1:0] base_wd;
    logic          len_we;
    logic [AW-1:0] len_wa;
    logic [DW-1:0] len_wd;
    logic [DW-1:0] base_m;
    logic [DW-1:0] len_m;

    // Shared adder.
    mrhc_pkg::alu_req_t alu_req;
    mrhc_pkg::alu_rsp_t alu_rsp;

    // Helpers.
    logic [IW-1:0] idx_w;
    logic [IW-1:0] cnt_w;
    logic [CW-1:0] i_inc;
    logic [CW-1:0] k_dec;
    logic [TW-1:0] total_w;

    assign idx_w   = IW'(run_index);
    assign cnt_w   = IW'(count_reg);
    assign i_inc   = i_reg + ONE_CNT;
    assign k_dec   = k_reg - ONE_CNT;
    assign total_w = TW'(count_reg);

    mrhc_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // A read of entry 0 that was never written returns the reset run.
    assign base_m = base_q0_reg ? '0 : base_q_reg;
    assign len_m  = len_q0_reg ? '1 : len_q_reg;

    // Run table: one write per array and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (base_we)
        begin
            base_mem[base_wa] <= base_wd;
        end
        if (len_we)
        begin
            len_mem[len_wa] <= len_wd;
        end
        base_q_reg <= base_mem[rd_addr];
        len_q_reg  <= len_mem[rd_addr];
    end

    // Entry 0 tracking and read-side flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base0_fresh_reg <= 1'b1;
            len0_fresh_reg  <= 1'b1;
            base_q0_reg     <= 1'b0;
            len_q0_reg      <= 1'b0;
        end
        else
        begin
            base_q0_reg <= base0_fresh_reg && (rd_addr == '0);
            len_q0_reg  <= len0_fresh_reg && (rd_addr == '0);
            if (base_we && (base_wa == '0))
            begin
                base0_fresh_reg <= 1'b0;
            end
            if (len_we && (len_wa == '0))
            begin
                len0_fresh_reg <= 1'b0;
            end
        end
    end

    // Sequencer: one table entry is loaded, then in insert mode compared one test at a time.
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        rs_next        = rs_reg;
        re_next        = re_reg;
        ovf_next       = ovf_reg;
        valid_next     = valid_reg;
        res_base_next  = res_base_reg;
        res_bytes_next = res_bytes_reg;
        rd_addr        = i_reg[AW-1:0];
        base_we        = 1'b0;
        base_wa        = i_reg[AW-1:0];
        base_wd        = start_reg;
        len_we         = 1'b0;
        len_wa         = i_reg[AW-1:0];
        len_wd         = alu_rsp.sum;
        alu_req.op     = mrhc_pkg::ALU_SUB;
        alu_req.a      = rs_reg;
        alu_req.b      = start_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next      = mode;
                    start_next     = hole_start & mrhc_pkg::PAGE_MASK_HIGH;
                    end_next       = hole_end | mrhc_pkg::PAGE_MASK_LOW;
                    ovf_next       = 1'b0;
                    valid_next     = mode && (idx_w < cnt_w);
                    res_base_next  = '0;
                    res_bytes_next = '0;
                    i_next         = mode ? idx_w[CW-1:0] : '0;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                // Address was set up by i_reg; data is ready next cycle.
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                alu_req.op = mrhc_pkg::ALU_ADD;
                alu_req.a  = base_m;
                alu_req.b  = len_m;
                rs_next    = base_m;
                re_next    = alu_rsp.sum;
                if (mode_reg)
                begin
                    if (valid_reg)
                    begin
                        res_base_next  = base_m;
                        res_bytes_next = len_m;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_C1;
                end
            end
            S_C1:
            begin
                // Run base below the hole start?
                alu_req.op = mrhc_pkg::ALU_SUB;
                alu_req.a  = rs_reg;
                alu_req.b  = start_reg;
                state_next = alu_rsp.lt ? S_C2 : S_C3;
            end
            S_C2:
            begin
                // Hole start below the run end: the run gets split, or overflow is flagged if the table is full.
                alu_req.op = mrhc_pkg::ALU_SUB;
                alu_req.a  = start_reg;
                alu_req.b  = re_reg;
                if (!alu_rsp.lt)
                begin
                    state_next = S_C3;
                end
                else if (count_reg == MAX_CNT)
                begin
                    ovf_next   = 1'b1;
                    i_next     = i_inc;
                    state_next = (i_inc < count_reg) ? S_READ : S_DONE;
                end
                else
                begin
                    k_next     = count_reg;
                    state_next = S_SPL_A;
                end
            end
            S_C3:
            begin
                // Run base below the hole end?
                alu_req.op = mrhc_pkg::ALU_SUB;
                alu_req.a  = rs_reg;
                alu_req.b  = end_reg;
                if (alu_rsp.lt)
                begin
                    state_next = S_C4;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = (i_inc < count_reg) ? S_READ : S_DONE;
                end
            end
            S_C4:
            begin
                // Hole end below the run end: trim the run and stop.
                alu_req.op = mrhc_pkg::ALU_SUB;
                alu_req.a  = end_reg;
                alu_req.b  = re_reg;
                if (alu_rsp.lt)
                begin
                    state_next = S_TRIM_A;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = (i_inc < count_reg) ? S_READ : S_DONE;
                end
            end
            S_SPL_A:
            begin
                // Lower part keeps its base and ends just below the hole.
                alu_req.op = mrhc_pkg::ALU_SUB;
                alu_req.a  = start_reg;
                alu_req.b  = rs_reg;
                len_we     = 1'b1;
                len_wa     = i_reg[AW-1:0];
                len_wd     = alu_rsp.sum;
                state_next = (k_reg > i_inc) ? S_SH_RD : S_SPL_B;
            end
            S_SH_RD:
            begin
                rd_addr    = k_dec[AW-1:0];
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                // Move one entry up by one place, from the top down.
                base_we    = 1'b1;
                base_wa    = k_reg[AW-1:0];
                base_wd    = base_m;
                len_we     = 1'b1;
                len_wa     = k_reg[AW-1:0];
                len_wd     = len_m;
                k_next     = k_dec;
                state_next = (k_dec > i_inc) ? S_SH_RD : S_SPL_B;
            end
            S_SPL_B:
            begin
                // Upper part starts at the hole start; the scan goes on with it.
                alu_req.op = mrhc_pkg::ALU_SUB;
                alu_req.a  = re_reg;
                alu_req.b  = start_reg;
                base_we    = 1'b1;
                base_wa    = i_inc[AW-1:0];
                base_wd    = start_reg;
                len_we     = 1'b1;
                len_wa     = i_inc[AW-1:0];
                len_wd     = alu_rsp.sum;
                count_next = count_reg + ONE_CNT;
                i_next     = i_inc;
                state_next = S_READ;
            end
            S_TRIM_A:
            begin
                alu_req.op = mrhc_pkg::ALU_ADD1;
                alu_req.a  = end_reg;
                alu_req.b  = '0;
                base_we    = 1'b1;
                base_wa    = i_reg[AW-1:0];
                base_wd    = alu_rsp.sum;
                state_next = S_TRIM_B;
            end
            S_TRIM_B:
            begin
                alu_req.op = mrhc_pkg::ALU_SUB1;
                alu_req.a  = re_reg;
                alu_req.b  = end_reg;
                len_we     = 1'b1;
                len_wa     = i_reg[AW-1:0];
                len_wd     = alu_rsp.sum;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= ONE_CNT;
            i_reg     <= '0;
            k_reg     <= '0;
            mode_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            mode_reg  <= mode_next;
            ovf_reg   <= ovf_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        start_reg     <= start_next;
        end_reg       <= end_next;
        rs_reg        <= rs_next;
        re_reg        <= re_next;
        res_base_reg  <= res_base_next;
        res_bytes_reg <= res_bytes_next;
    end

    // Result beat.
    assign busy        = (state_reg != S_IDLE);
    assign done        = (state_reg == S_DONE);
    assign run_base    = res_base_reg;
    assign run_bytes   = res_bytes_reg;
    assign run_total   = total_w[mrhc_pkg::TOTAL_W-1:0];
    assign overflow    = ovf_reg;
    assign index_valid = valid_reg;

    // The run count stays between one and the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= ONE_CNT) && (count_reg <= MAX_CNT))
        else $error("run count out of range");

    // A dropped split is only reported when the table is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> (count_reg == MAX_CNT))
        else $error("overflow reported with room in the table");

    // A result beat is followed by an idle cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after its result beat");

    // An accepted start holds the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("start accepted without going busy");

endmodule
